>>> src/fsmf_pkg.sv
package fsmf_pkg;

  // default sizes
  localparam int MAX_NEEDLE_DEF  = 32;
  localparam int OFFSET_BITS_DEF = 32;

  // needle storage: four 64-bit registers of eight bytes each
  localparam int NEEDLE_REGS  = 4;
  localparam int NEEDLE_BYTES = 32;
  localparam int LEN_BITS     = 6;

  // byte and result widths
  localparam int BYTE_BITS   = 8;
  localparam int RESULT_BITS = 32;

  // configuration bus
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_ADDR_BITS = 6;

  // register index, taken from paddr[5:3]
  typedef enum logic [2:0] {
    REG_NEEDLE_0   = 3'd0,
    REG_NEEDLE_1   = 3'd1,
    REG_NEEDLE_2   = 3'd2,
    REG_NEEDLE_3   = 3'd3,
    REG_NEEDLE_LEN = 3'd4
  } reg_idx_t;

  typedef logic [NEEDLE_BYTES-1:0][BYTE_BITS-1:0] needle_t;

endpackage

>>> src/fsmf_cmp.sv
module fsmf_cmp #(
  parameter int MAX_NEEDLE = fsmf_pkg::MAX_NEEDLE_DEF,
  parameter int LEN_W      = $clog2(MAX_NEEDLE + 1)
) (
  input  logic [MAX_NEEDLE-1:0][fsmf_pkg::BYTE_BITS-1:0] window,
  input  fsmf_pkg::needle_t                               needle,
  input  logic [LEN_W-1:0]                                len,
  output logic                                            equal
);

  localparam int IDX_W = (LEN_W + 1 > 6) ? LEN_W + 1 : 6;
  localparam logic [IDX_W-1:0] NB = IDX_W'(fsmf_pkg::NEEDLE_BYTES);

  logic [MAX_NEEDLE-1:0] lane_ok;

  // lane i holds the window byte that must equal needle byte len-1-i
  for (genvar i = 0; i < MAX_NEEDLE; i++) begin : g_lane
    logic [IDX_W-1:0]               j;
    logic [fsmf_pkg::BYTE_BITS-1:0] nb;
    logic                           used;

    always_comb begin
      used = (IDX_W'(len) > IDX_W'(i));
      j    = IDX_W'(len) - IDX_W'(i) - IDX_W'(1);
      // needle bytes past the stored ones read as zero
      if (j < NB) begin
        nb = needle[j[4:0]];
      end else begin
        nb = '0;
      end
      lane_ok[i] = !used || (window[i] == nb);
    end
  end

  assign equal = &lane_ok;

endmodule

>>> src/first_substring_match_finder_core.sv
// First substring match finder.
// Haystack bytes arrive on the in_ stream, one byte per request, with tlast
// on the final byte of each haystack. The needle (up to 32 bytes) and its
// length are written over the cfg_ APB port; the user must do so only while
// no haystack is in flight, which the block does not enforce. For each
// haystack one result leaves on the out_ stream: tuser=1 with the offset of
// the first match in tdata, or tuser=0 and offset 0 when the haystack ended
// without a match. After a match nothing more is sent until the last byte,
// which restarts the search. An empty needle matches at offset 0 on the
// first byte. A taken byte passes through the input register, the compare
// and then the result register. Throughput is one byte per cycle while the
// result is not stalled, set by the single compare stage between the input
// register and the result register.
// Reset clears the window, byte count, match flag, needle and length.
// A stalled result holds in the result register; one more byte can sit in
// the input register, after which in_tready drops until the result is taken.
module first_substring_match_finder_core #(
  parameter int MAX_NEEDLE  = fsmf_pkg::MAX_NEEDLE_DEF,
  parameter int OFFSET_BITS = fsmf_pkg::OFFSET_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: data_byte[7:0]
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [fsmf_pkg::BYTE_BITS-1:0]       in_tdata,
  input  logic                                 in_tlast,
  // out_tdata: match_offset[31:0]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [fsmf_pkg::RESULT_BITS-1:0]     out_tdata,
  // out_tuser: found[0]
  output logic                                 out_tuser,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [fsmf_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [fsmf_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic [fsmf_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
  localparam int BB    = fsmf_pkg::BYTE_BITS;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
  localparam logic [7:0] MAX_N8 = 8'(MAX_NEEDLE);

  // configuration registers
  logic [fsmf_pkg::CFG_DATA_BITS-1:0] needle_r [fsmf_pkg::NEEDLE_REGS];
  logic [fsmf_pkg::LEN_BITS-1:0]      needle_len_r;
  logic [2:0]                         cfg_idx;
  logic                               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < fsmf_pkg::NEEDLE_REGS; k++) begin
        needle_r[k] <= '0;
      end
      needle_len_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        fsmf_pkg::REG_NEEDLE_0:   needle_r[0] <= cfg_pwdata;
        fsmf_pkg::REG_NEEDLE_1:   needle_r[1] <= cfg_pwdata;
        fsmf_pkg::REG_NEEDLE_2:   needle_r[2] <= cfg_pwdata;
        fsmf_pkg::REG_NEEDLE_3:   needle_r[3] <= cfg_pwdata;
        fsmf_pkg::REG_NEEDLE_LEN: needle_len_r <= cfg_pwdata[fsmf_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      fsmf_pkg::REG_NEEDLE_0:   cfg_prdata = needle_r[0];
      fsmf_pkg::REG_NEEDLE_1:   cfg_prdata = needle_r[1];
      fsmf_pkg::REG_NEEDLE_2:   cfg_prdata = needle_r[2];
      fsmf_pkg::REG_NEEDLE_3:   cfg_prdata = needle_r[3];
      fsmf_pkg::REG_NEEDLE_LEN: cfg_prdata = fsmf_pkg::CFG_DATA_BITS'(needle_len_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // needle as bytes, byte 0 lowest
  fsmf_pkg::needle_t needle;
  always_comb begin
    for (int k = 0; k < fsmf_pkg::NEEDLE_BYTES; k++) begin
      needle[k] = needle_r[k / 8][(k % 8) * BB +: BB];
    end
  end

  // length saturated to the window depth
  logic [7:0]       len8;
  logic [LEN_W-1:0] len;
  always_comb begin
    len8 = 8'(needle_len_r);
    if (len8 > MAX_N8) begin
      len8 = MAX_N8;
    end
    len = LEN_W'(len8);
  end

  // input register
  logic          s1_valid_r;
  logic [BB-1:0] s1_byte_r;
  logic          s1_last_r;
  logic          advance;

  assign advance   = !out_tvalid || out_tready;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // haystack state
  logic [MAX_NEEDLE-1:0][BB-1:0] window_r, window_shift;
  logic [OFFSET_BITS-1:0]        seen_r;
  logic                          reported_r;

  always_comb begin
    window_shift[0] = s1_byte_r;
    for (int k = 1; k < MAX_NEEDLE; k++) begin
      window_shift[k] = window_r[k-1];
    end
  end

  logic eq;
  fsmf_cmp #(
    .MAX_NEEDLE (MAX_NEEDLE),
    .LEN_W      (LEN_W)
  ) u_cmp (
    .window (window_shift),
    .needle (needle),
    .len    (len),
    .equal  (eq)
  );

  // match decision and offset
  logic                     enough;
  logic                     hit;
  logic                     emit;
  logic [OFFSET_BITS-1:0]   offset;
  logic [OFFSET_BITS+31:0]  offset_ext;
  logic [OFFSET_BITS-1:0]   seen_inc;

  always_comb begin
    enough   = ({1'b0, seen_r} + (OFFSET_BITS+1)'(1)) >= (OFFSET_BITS+1)'(len);
    seen_inc = (seen_r == OFFSET_MAX) ? OFFSET_MAX : seen_r + OFFSET_BITS'(1);
    hit      = 1'b0;
    offset   = '0;
    if (!reported_r) begin
      if (len == '0) begin
        hit = 1'b1;
      end else if (enough && eq) begin
        hit = 1'b1;
        if (seen_r == OFFSET_MAX) begin
          offset = OFFSET_MAX;
        end else begin
          offset = seen_r - OFFSET_BITS'(len) + OFFSET_BITS'(1);
        end
      end
    end
    emit       = hit || (s1_last_r && !reported_r);
    offset_ext = {32'b0, offset};
  end

  logic step;
  assign step = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= '0;
      seen_r     <= '0;
      reported_r <= 1'b0;
    end else if (step) begin
      if (s1_last_r) begin
        window_r   <= '0;
        seen_r     <= '0;
        reported_r <= 1'b0;
      end else begin
        window_r   <= window_shift;
        seen_r     <= seen_inc;
        reported_r <= reported_r || hit;
      end
    end
  end

  // result register
  logic                             out_valid_r;
  logic                             out_found_r;
  logic [fsmf_pkg::RESULT_BITS-1:0] out_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_found_r  <= hit;
      out_offset_r <= offset_ext[31:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_offset_r;

endmodule

>>> src/fsmf_checker.sv
module fsmf_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [fsmf_pkg::RESULT_BITS-1:0]   out_tdata,
  input logic                               out_tuser,
  input logic                               cfg_pready
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a no-match result carries offset zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("no-match result with nonzero offset");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // config port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

endmodule

bind first_substring_match_finder_core fsmf_checker u_fsmf_checker (.*);
